// ===== hw/rtl/mwep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwep_pkg - shared definitions for the serial EEPROM bus port
// Port addresses, parameter defaults and the store request type.
// ----------------------------------------------------------------------------
package mwep_pkg;

	// Byte bus addresses of the three ports
	localparam logic [23:0] PORT_DO = 24'hF14001;
	localparam logic [23:0] PORT_DI = 24'hF14801;
	localparam logic [23:0] PORT_CS = 24'hF15001;

	// Default geometry of the store
	localparam int WORDS_DEF        = 64;
	localparam int ADDRESS_BITS_DEF = 6;
	localparam int WORD_BITS_DEF    = 16;

	// Write request to the word store
	typedef struct packed {
		logic wr;    // write one word
		logic fill;  // sweep the whole store with one value
	} mwep_req_t;

endpackage

// ===== hw/rtl/mwep_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwep_store - word store of the serial EEPROM
// Single-port-write RAM with registered read and a fill sweep that runs
// after reset (all ones) and on a fill request, one word per cycle.
// ----------------------------------------------------------------------------
module mwep_store import mwep_pkg::*; #(
	parameter int WORDS     = WORDS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int IW       = $clog2(WORDS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mwep_req_t            req,
	input  logic [IW-1:0]        addr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [IW-1:0]        rd_addr,
	output logic [WORD_BITS-1:0] rdata,
	output logic                 filling
);

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 fill_q;
	logic [IW-1:0]        fill_cnt_q;
	logic [WORD_BITS-1:0] fill_val_q;

	// Run the fill sweep: start at reset with all ones, restart on request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= 1'b1;
			fill_cnt_q <= '0;
			fill_val_q <= '1;
		end else if (req.fill) begin
			fill_q     <= 1'b1;
			fill_cnt_q <= '0;
			fill_val_q <= wdata;
		end else if (fill_q) begin
			if (fill_cnt_q == IW'(WORDS - 1)) begin
				fill_q <= 1'b0;
			end
			fill_cnt_q <= fill_cnt_q + 1'b1;
		end
	end

	// Write one word or the next sweep word; the read data is registered
	always_ff @(posedge clk) begin
		if (fill_q) begin
			mem[fill_cnt_q] <= fill_val_q;
		end else if (req.wr) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	assign rdata   = rdata_q;
	assign filling = fill_q;

endmodule

// ===== hw/rtl/microwire_eeprom_bus_port.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microwire_eeprom_bus_port - bit-banged serial EEPROM behind three byte ports
// Command machine for start bit, opcode, address and data bits over a RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. For each item, the
// accept cycle issues the RAM read at the current address and the next
// cycle updates the command machine and writes the RAM. The result
// shows on read_data with done high for one cycle, the cycle after that,
// and must be taken then: there is no way to hold it off. A new item can be
// taken in the same cycle as done. Reset, and write-all or erase-all while
// writes are enabled, start a fill sweep of the store, one word per cycle,
// which keeps busy high until all WORDS (64 by default) words are written;
// right after reset the store is swept to all ones before any item is taken.
module microwire_eeprom_bus_port import mwep_pkg::*; #(
	parameter int WORDS        = WORDS_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [23:0] offset,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [7:0]  read_data
);

	localparam int AB  = ADDRESS_BITS;
	localparam int WB  = WORD_BITS;
	localparam int IW  = $clog2(WORDS);
	localparam int EW  = AB + IW;
	localparam int CW  = $clog2(((WB > AB) ? WB : AB) + 1);
	localparam int IXB = $clog2(WB);

	// Command machine phases
	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_OPA   = 3'd1;
	localparam logic [2:0] PH_OPB   = 3'd2;
	localparam logic [2:0] PH_ADDR  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_BUSY  = 3'd5;
	localparam logic [2:0] PH_RD    = 3'd6;

	// Opcodes
	localparam logic [1:0] OP_EXT   = 2'b00;
	localparam logic [1:0] OP_WRITE = 2'b01;
	localparam logic [1:0] OP_READ  = 2'b10;
	localparam logic [1:0] OP_ERASE = 2'b11;

	// Extended commands under OP_EXT (top two address bits)
	localparam logic [1:0] EXT_WDS  = 2'b00;
	localparam logic [1:0] EXT_WRAL = 2'b01;
	localparam logic [1:0] EXT_ERAL = 2'b10;
	localparam logic [1:0] EXT_WEN  = 2'b11;

	// Decoded port select
	localparam logic [1:0] SEL_NONE = 2'd0;
	localparam logic [1:0] SEL_DO   = 2'd1;
	localparam logic [1:0] SEL_DI   = 2'd2;
	localparam logic [1:0] SEL_CS   = 2'd3;

	logic [2:0]    phase_q, phase_n;
	logic [1:0]    opcode_q, opcode_n;
	logic [AB-1:0] addr_q, addr_n;
	logic [WB-1:0] data_q, data_n;
	logic [CW-1:0] cnt_q, cnt_n, cnt_dec;
	logic          wa_q, wa_n;

	logic          valid_s1;
	logic          cmd_s1;
	logic [1:0]    sel_s1;
	logic          d_s1;

	logic          done_q;
	logic          bit_q;
	logic          bit_n;

	logic          accept;
	logic [1:0]    sel;
	logic [EW-1:0] rd_ext, wr_ext;
	logic          rd_in_range, wr_in_range;
	logic [WB-1:0] wr_word;
	logic [WB-1:0] rdata;
	logic          filling;
	mwep_req_t     req;

	assign accept = start && !busy;
	assign busy   = valid_s1 || filling;

	// Decode the port at accept
	always_comb begin
		if (offset == PORT_CS) begin
			sel = SEL_CS;
		end else if (offset == PORT_DI) begin
			sel = SEL_DI;
		end else if (offset == PORT_DO) begin
			sel = SEL_DO;
		end else begin
			sel = SEL_NONE;
		end
	end

	// Hold the accepted item in stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			sel_s1 <= sel;
			d_s1   <= write_data[0];
		end
	end

	// Map addresses onto the store and check the range
	assign rd_ext      = {{IW{1'b0}}, addr_q};
	assign wr_ext      = {{IW{1'b0}}, addr_n};
	assign rd_in_range = rd_ext < EW'(WORDS);
	assign wr_in_range = wr_ext < EW'(WORDS);
	assign cnt_dec     = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;

	// Advance the command machine for the item in stage 1
	always_comb begin
		phase_n  = phase_q;
		opcode_n = opcode_q;
		addr_n   = addr_q;
		data_n   = data_q;
		cnt_n    = cnt_q;
		wa_n     = wa_q;
		bit_n    = 1'b0;
		req      = '0;
		wr_word  = '1;
		if (valid_s1) begin
			if (sel_s1 == SEL_CS) begin
				phase_n  = PH_START;
				opcode_n = OP_EXT;
				addr_n   = '0;
				data_n   = '0;
				cnt_n    = CW'(AB);
				wa_n     = 1'b1;
			end else if (cmd_s1 && sel_s1 == SEL_DI) begin
				case (phase_q)
					PH_START: begin
						phase_n = PH_OPA;
					end
					PH_OPA: begin
						opcode_n = {d_s1, 1'b0};
						phase_n  = PH_OPB;
					end
					PH_OPB: begin
						opcode_n = {opcode_q[1], d_s1};
						phase_n  = PH_ADDR;
						addr_n   = '0;
						cnt_n    = CW'(AB);
					end
					PH_ADDR: begin
						addr_n = {addr_q[AB-2:0], d_s1};
						cnt_n  = cnt_dec;
						if (cnt_dec == '0) begin
							case (opcode_q)
								OP_EXT: begin
									case (addr_n[AB-1 -: 2])
										EXT_WDS: begin
											wa_n    = 1'b0;
											phase_n = PH_START;
										end
										EXT_WRAL: begin
											phase_n = PH_DATA;
											cnt_n   = CW'(WB);
											data_n  = '0;
										end
										EXT_ERAL: begin
											req.fill = wa_q;
											phase_n  = PH_BUSY;
										end
										EXT_WEN: begin
											wa_n    = 1'b1;
											phase_n = PH_START;
										end
										default: begin
											phase_n = PH_START;
										end
									endcase
								end
								OP_WRITE: begin
									phase_n = PH_DATA;
									cnt_n   = CW'(WB);
									data_n  = '0;
								end
								OP_READ: begin
									phase_n = PH_RD;
									cnt_n   = CW'(WB);
									data_n  = '0;
								end
								OP_ERASE: begin
									req.wr  = wa_q && wr_in_range;
									phase_n = PH_BUSY;
								end
								default: begin
									phase_n = PH_START;
								end
							endcase
						end
					end
					PH_DATA: begin
						data_n = {data_q[WB-2:0], d_s1};
						cnt_n  = cnt_dec;
						if (cnt_dec == '0) begin
							wr_word = data_n;
							phase_n = PH_BUSY;
							if (opcode_q == OP_EXT) begin
								req.fill = wa_q;
							end else begin
								req.wr = wa_q && wr_in_range;
							end
						end
					end
					default: begin
						phase_n = PH_OPA;
					end
				endcase
			end else if (!cmd_s1 && sel_s1 == SEL_DO) begin
				case (phase_q)
					PH_BUSY: begin
						phase_n = PH_START;
						bit_n   = 1'b0;
					end
					PH_RD: begin
						cnt_n = cnt_dec;
						bit_n = rd_in_range ? rdata[cnt_dec[IXB-1:0]] : 1'b1;
						if (cnt_dec == '0) begin
							phase_n = PH_START;
						end
					end
					default: begin
						bit_n = 1'b1;
					end
				endcase
			end
		end
	end

	// Update the machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			opcode_q <= OP_EXT;
			addr_q   <= '0;
			data_q   <= '0;
			cnt_q    <= CW'(AB);
			wa_q     <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			opcode_q <= opcode_n;
			addr_q   <= addr_n;
			data_q   <= data_n;
			cnt_q    <= cnt_n;
			wa_q     <= wa_n;
		end
	end

	// Register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			bit_q <= bit_n;
		end
	end

	assign done      = done_q;
	assign read_data = {7'b0, bit_q};

	mwep_store #(
		.WORDS     (WORDS),
		.WORD_BITS (WB)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.addr    (wr_ext[IW-1:0]),
		.wdata   (wr_word),
		.rd_addr (rd_ext[IW-1:0]),
		.rdata   (rdata),
		.filling (filling)
	);

`ifndef SYNTHESIS
	// Every accepted item yields exactly one result, registered after stage 1
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted item gave no result");

	// No result without an item in stage 1 the cycle before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result without item");

	// No item is processed while the store is being swept
	a_sweep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		filling |-> !valid_s1)
		else $error("item processed during fill sweep");

	// Read data phase always has bits left to shift out
	a_rd_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RD |-> cnt_q != '0)
		else $error("read phase with empty bit count");
`endif

endmodule

// ===== verif/mwep_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwep_scoreboard_pkg - predictor and scoreboard for the serial EEPROM port
// Tracks the command machine and the 64 x 16 word store for every accepted
// item and checks each read_data byte against the oldest predicted byte.
// ----------------------------------------------------------------------------
package mwep_scoreboard_pkg;
	import mwep_pkg::*;

	// Bus access direction
	localparam bit CMD_READ  = 1'b0;
	localparam bit CMD_WRITE = 1'b1;

	// Serial opcodes
	localparam logic [1:0] OP_EXT   = 2'b00;
	localparam logic [1:0] OP_WRITE = 2'b01;
	localparam logic [1:0] OP_READ  = 2'b10;
	localparam logic [1:0] OP_ERASE = 2'b11;

	// Extended commands, top two address bits under OP_EXT
	localparam logic [1:0] EXT_WDS  = 2'b00;
	localparam logic [1:0] EXT_WRAL = 2'b01;
	localparam logic [1:0] EXT_ERAL = 2'b10;
	localparam logic [1:0] EXT_EWEN = 2'b11;

	localparam logic [WORD_BITS_DEF-1:0] ERASED_WORD = '1;

	typedef enum logic [4:0] {
		S_NULL     = 5'd0,
		S_START    = 5'd1,
		S_OPA      = 5'd2,
		S_OPB      = 5'd3,
		S_OP0      = 5'd4,
		S_OP1      = 5'd5,
		S_OP2      = 5'd6,
		S_OP3      = 5'd7,
		S_SUB      = 5'd8,
		S_ADDR     = 5'd9,
		S_WDS      = 5'd10,
		S_WRAL     = 5'd11,
		S_ERAL     = 5'd12,
		S_WEN      = 5'd13,
		S_WRAL_GO  = 5'd14,
		S_DATA     = 5'd15,
		S_BUSY     = 5'd16,
		S_WR_DATA  = 5'd17,
		S_WR_GO    = 5'd18,
		S_RD       = 5'd19,
		S_ER_GO    = 5'd20
	} eeprom_phase_t;

	typedef struct {
		bit          cmd;
		logic [23:0] offset;
		logic [7:0]  read_data;
	} read_byte_t;

	class eeprom_scoreboard_t;
		logic [WORD_BITS_DEF-1:0]    words [WORDS_DEF];
		eeprom_phase_t               phase;
		eeprom_phase_t               resume_phase;
		logic [1:0]                  opcode;
		logic [ADDRESS_BITS_DEF-1:0] addr_sr;
		logic [2:0]                  addr_left;
		logic [WORD_BITS_DEF-1:0]    data_sr;
		logic [4:0]                  data_left;
		bit                          wr_enabled;
		bit                          chain_next;
		read_byte_t                  expected_bytes[$];
		int                          failures;

		function new();
			phase = S_START;
			resume_phase = S_NULL;
			opcode = '0;
			addr_sr = '0;
			addr_left = 3'(ADDRESS_BITS_DEF);
			data_sr = '0;
			data_left = 5'(WORD_BITS_DEF);
			wr_enabled = 1'b0;
			chain_next = 1'b0;
			failures = 0;
			fill_words(ERASED_WORD);
		endfunction

		function void fill_words(logic [WORD_BITS_DEF-1:0] v);
			foreach (words[i]) words[i] = v;
		endfunction

		function void open_address(eeprom_phase_t ret);
			resume_phase = ret;
			phase = S_ADDR;
			addr_left = 3'(ADDRESS_BITS_DEF);
			addr_sr = '0;
		endfunction

		function void open_data(eeprom_phase_t ret);
			resume_phase = ret;
			phase = S_DATA;
			data_left = 5'(WORD_BITS_DEF);
			data_sr = '0;
			chain_next = 1'b1;
		endfunction

		// Advance the command machine by one serial data-in bit
		function void shift_bit(bit d);
			bit again;
			again = 1'b1;
			while (again) begin
				again = 1'b0;
				case (phase)
					S_START: phase = S_OPA;
					S_OPA: begin
						opcode = {d, 1'b0};
						phase = S_OPB;
					end
					S_OPB: begin
						opcode[0] = d;
						chain_next = 1'b0;
						case (opcode)
							OP_EXT:   phase = S_OP0;
							OP_WRITE: phase = S_OP1;
							OP_READ:  phase = S_OP2;
							default:  phase = S_OP3;
						endcase
						again = 1'b1;
					end
					S_OP0: begin
						open_address(S_SUB);
						chain_next = 1'b1;
					end
					S_OP1: begin
						open_address(S_WR_DATA);
						chain_next = 1'b1;
					end
					S_OP2: begin
						open_address(S_RD);
						data_left = 5'(WORD_BITS_DEF);
						data_sr = '0;
					end
					S_OP3: begin
						open_address(S_ER_GO);
						chain_next = 1'b1;
					end
					S_SUB: begin
						case (addr_sr[ADDRESS_BITS_DEF-1 -: 2])
							EXT_WDS:  phase = S_WDS;
							EXT_WRAL: phase = S_WRAL;
							EXT_ERAL: phase = S_ERAL;
							default:  phase = S_WEN;
						endcase
						again = 1'b1;
					end
					S_WDS: begin
						wr_enabled = 1'b0;
						phase = S_START;
					end
					S_WRAL: open_data(S_WRAL_GO);
					S_WRAL_GO: begin
						if (wr_enabled) fill_words(data_sr);
						phase = S_BUSY;
					end
					S_ERAL: begin
						if (wr_enabled) fill_words(ERASED_WORD);
						phase = S_BUSY;
					end
					S_WEN: begin
						wr_enabled = 1'b1;
						phase = S_START;
					end
					S_WR_DATA: open_data(S_WR_GO);
					S_WR_GO: begin
						if (wr_enabled) words[addr_sr] = data_sr;
						phase = S_BUSY;
					end
					S_ER_GO: begin
						if (wr_enabled) words[addr_sr] = ERASED_WORD;
						phase = S_BUSY;
					end
					S_DATA: begin
						data_sr = {data_sr[WORD_BITS_DEF-2:0], d};
						if (data_left != 0) data_left = data_left - 1'b1;
						if (data_left == 0) begin
							phase = resume_phase;
							if (chain_next) again = 1'b1;
						end
					end
					S_ADDR: begin
						addr_sr = {addr_sr[ADDRESS_BITS_DEF-2:0], d};
						if (addr_left != 0) addr_left = addr_left - 1'b1;
						if (addr_left == 0) begin
							phase = resume_phase;
							if (chain_next) again = 1'b1;
						end
					end
					// busy, read data pending: the bit is taken as a start bit
					default: phase = S_OPA;
				endcase
			end
		endfunction

		// Answer a data-out read: status or next read bit, MSB first
		function logic [7:0] read_data_out();
			logic [7:0] bit_out;
			bit_out = 8'd1;
			if (phase == S_BUSY) begin
				phase = S_START;
				bit_out = 8'd0;
			end else if (phase == S_RD) begin
				if (data_left != 0) data_left = data_left - 1'b1;
				bit_out = {7'd0, words[addr_sr][data_left[3:0]]};
				if (data_left == 0) phase = S_START;
			end
			return bit_out;
		endfunction

		// Note one accepted item and queue the byte it must return
		function void note_access(bit c, logic [23:0] o, logic [7:0] w);
			read_byte_t e;
			e.cmd = c;
			e.offset = o;
			e.read_data = 8'd0;
			if (o == PORT_CS) begin
				phase = S_START;
				opcode = '0;
				resume_phase = S_NULL;
				addr_sr = '0;
				addr_left = 3'(ADDRESS_BITS_DEF);
				data_sr = '0;
				data_left = 5'(WORD_BITS_DEF);
				wr_enabled = 1'b1;
			end else if (c == CMD_WRITE) begin
				if (o == PORT_DI) shift_bit(w[0]);
			end else if (o == PORT_DO) begin
				e.read_data = read_data_out();
			end
			expected_bytes.push_back(e);
		endfunction

		// Compare one returned byte with the oldest prediction
		function void check_read_data(logic [7:0] got);
			read_byte_t e;
			if (expected_bytes.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("read_data %h returned with no item outstanding", got);
			end else begin
				e = expected_bytes.pop_front();
				if (got !== e.read_data) begin
					failures++;
					if (failures <= 10)
						$display("read_data mismatch, offset %h cmd %0d: expected %h, got %h",
							e.offset, e.cmd, e.read_data, got);
				end
			end
		endfunction
	endclass

endpackage

// ===== verif/microwire_eeprom_bus_port_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microwire_eeprom_bus_port_test - testbench for the serial EEPROM bus port
// Drives byte bus accesses through the start/busy handshake: a short directed
// part, then mostly well-formed serial commands with random content mixed
// with noise and cut-off commands. Every done byte is checked in order.
// ----------------------------------------------------------------------------
module microwire_eeprom_bus_port_test;
	import mwep_pkg::*;
	import mwep_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PORT_ITEMS  = 820;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cmd;
	logic [23:0] offset;
	logic [7:0]  write_data;
	logic        done;
	logic [7:0]  read_data;

	eeprom_scoreboard_t sb;
	int                 cycles;
	int                 port_items;
	bit                 sender_idles;

	microwire_eeprom_bus_port i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.offset     (offset),
		.write_data (write_data),
		.done       (done),
		.read_data  (read_data)
	);

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Check every returned byte
	always @(posedge clk) begin
		if (arst_n && done) sb.check_read_data(read_data);
	end

	// Drive one bus access and hold it until it is taken
	task automatic access(input bit c, input logic [23:0] o, input logic [7:0] w);
		int gap;
		if (sender_idles && $urandom_range(99) < 18) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		offset <= o;
		write_data <= w;
		do @(posedge clk); while (busy);
		sb.note_access(c, o, w);
		if (o == PORT_DO || o == PORT_DI || o == PORT_CS) port_items++;
	endtask

	// Write one serial bit to the data-in port, upper bits random
	task automatic feed_bit(input bit d);
		logic [6:0] upper;
		upper = 7'($urandom);
		access(CMD_WRITE, PORT_DI, {upper, d});
	endtask

	// Send start bit, opcode, address and, for write and write-all, data; cut off after max_bits
	task automatic send_command(input logic [1:0] op, input logic [ADDRESS_BITS_DEF-1:0] addr,
			input logic [WORD_BITS_DEF-1:0] data, input int max_bits);
		logic [24:0] bits;
		int          nbits;
		bits = {1'($urandom), op, addr, data};
		nbits = (op == OP_WRITE || (op == OP_EXT && addr[5:4] == EXT_WRAL)) ? 25 : 9;
		if (max_bits < nbits) nbits = max_bits;
		for (int i = 0; i < nbits; i++) feed_bit(bits[24 - i]);
	endtask

	task automatic read_bits(input int n);
		repeat (n) access(CMD_READ, PORT_DO, 8'($urandom));
	endtask

	// Hold off the sender until every predicted byte has come back
	task automatic wait_for_results();
		@(negedge clk);
		start <= 1'b0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [ADDRESS_BITS_DEF-1:0] addr;
		logic [WORD_BITS_DEF-1:0]    data;
		logic [23:0]                 noise_offset;
		int                          kind;
		int                          op_pick;
		bit                          paused;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_READ;
		offset = '0;
		write_data = '0;
		sender_idles = 1'b1;
		paused = 1'b0;
		sb = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle status, wrong-direction port accesses, ignored offsets
		access(CMD_READ, PORT_DO, 8'h00);
		access(CMD_READ, PORT_DI, 8'hFF);
		access(CMD_WRITE, PORT_DO, 8'hFF);
		access(CMD_READ, 24'h000000, 8'h00);
		access(CMD_WRITE, 24'hFFFFFF, 8'hFF);
		access(CMD_READ, 24'hFFFFFF, 8'h00);
		// erase-all while writes are still locked from reset, then busy and idle
		send_command(OP_EXT, {EXT_ERAL, 4'h0}, '0, 25);
		read_bits(2);
		// chip select, then a stray data-in bit and a status read mid-command
		access(CMD_WRITE, PORT_CS, 8'h00);
		feed_bit(1'b0);
		access(CMD_READ, PORT_DO, 8'h01);
		wait_for_results();

		// Random: mostly complete commands, some noise and cut-off commands
		while (port_items < PORT_ITEMS) begin
			sender_idles = !(port_items >= 350 && port_items < 520);
			if (!paused && port_items >= 600) begin
				wait_for_results();
				paused = 1'b1;
			end
			kind = $urandom_range(99);
			addr = $urandom_range(1) ? ADDRESS_BITS_DEF'($urandom_range(7))
				: ADDRESS_BITS_DEF'($urandom);
			case ($urandom_range(7))
				0:       data = '0;
				1:       data = '1;
				default: data = WORD_BITS_DEF'($urandom);
			endcase
			if (kind < 70) begin
				if ($urandom_range(9) == 0) access(1'($urandom), PORT_CS, 8'($urandom));
				op_pick = $urandom_range(99);
				if (op_pick < 30) begin
					send_command(OP_READ, addr, data, 25);
					read_bits(($urandom_range(4) == 0) ? $urandom_range(20) : 16);
				end else if (op_pick < 55) begin
					send_command(OP_WRITE, addr, data, 25);
					read_bits($urandom_range(3));
				end else if (op_pick < 65) begin
					send_command(OP_ERASE, addr, data, 25);
					read_bits($urandom_range(3));
				end else if (op_pick < 75) begin
					send_command(OP_EXT, {EXT_EWEN, addr[3:0]}, data, 25);
					read_bits($urandom_range(2));
				end else if (op_pick < 83) begin
					send_command(OP_EXT, {EXT_WDS, addr[3:0]}, data, 25);
					read_bits($urandom_range(2));
				end else if (op_pick < 92) begin
					send_command(OP_EXT, {EXT_WRAL, addr[3:0]}, data, 25);
					read_bits($urandom_range(3));
				end else begin
					send_command(OP_EXT, {EXT_ERAL, addr[3:0]}, data, 25);
					read_bits($urandom_range(3));
				end
			end else if (kind < 85) begin
				case ($urandom_range(3))
					0:       noise_offset = PORT_DO;
					1:       noise_offset = PORT_DI;
					default: noise_offset = 24'($urandom);
				endcase
				access(1'($urandom), noise_offset, 8'($urandom));
			end else if (kind < 95) begin
				send_command(2'($urandom), addr, data, $urandom_range(1, 24));
				read_bits($urandom_range(2));
			end else begin
				access(1'($urandom), PORT_CS, 8'($urandom));
			end
		end

		// Drain, then allow for a trailing fill sweep
		wait_for_results();
		repeat (80) @(posedge clk);
		if (sb.failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mwep_pkg.sv
hw/rtl/mwep_store.sv
hw/rtl/microwire_eeprom_bus_port.sv
verif/mwep_scoreboard_pkg.sv
verif/microwire_eeprom_bus_port_test.sv
